// File: hdl/ids_pkg.sv
package ids_pkg;

	// fixed field widths
	localparam int WORD_W   = 32;
	localparam int KIND_W   = 3;
	localparam int STATUS_W = 2;
	localparam int MODE_W   = 2;

	// default number of entries
	localparam int DEPTH_DEF = 64;

	// request kinds
	localparam logic [KIND_W-1:0] K_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] K_PUSH_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] K_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] K_POP_BACK   = 3'd3;
	localparam logic [KIND_W-1:0] K_INSERT     = 3'd4;
	localparam logic [KIND_W-1:0] K_ERASE      = 3'd5;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	// cell update modes
	localparam logic [MODE_W-1:0] CELL_HOLD  = 2'd0;
	localparam logic [MODE_W-1:0] CELL_OPEN  = 2'd1;
	localparam logic [MODE_W-1:0] CELL_CLOSE = 2'd2;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic signed [WORD_W-1:0] word;
	} cell_ctl_t;

endpackage

// File: hdl/indexed_deque_store.sv
// Double-ended queue of signed 32-bit words with positional access, built as a
// row of DEPTH cells, one entry per cell, kept dense from position 0. Every
// request (push/pop at either end, insert or erase at a position) moves the
// row at once: all cells at and behind the position shift one place toward
// or away from the front together, so a request is accepted every cycle and
// its result appears in the output register on the next cycle. The input is
// held off only while that output register holds a word not yet taken. A
// popped word is read from the front cell or the tail cell through one
// DEPTH-to-1 select. Requests on a full or empty store or with a position out
// of range are dropped and flagged in status; fill_count always reports the
// number of entries after the request. Entries are not cleared at reset.
module indexed_deque_store
	import ids_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1),
	parameter int IN_W  = ((WORD_W + CNT_W + 7) / 8) * 8,
	parameter int OUT_W = ((WORD_W + STATUS_W + CNT_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_W-1:0]   s_axis_tdata,  // value, position, zero fill
	input  logic [KIND_W-1:0] s_axis_tuser,  // kind
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_W-1:0]  m_axis_tdata   // taken_value, status, fill_count, zero fill
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic                     in_acc;
	logic [KIND_W-1:0]        kind;
	logic signed [WORD_W-1:0] value;
	logic [CNT_W-1:0]         position;

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_nxt;
	logic                     out_valid_q;
	logic signed [WORD_W-1:0] taken_q;
	logic [STATUS_W-1:0]      status_q;

	cell_ctl_t                ctl;
	logic [CNT_W-1:0]         cell_pos;
	logic [STATUS_W-1:0]      status_nxt;
	logic                     take;
	logic [CNT_W-1:0]         rd_pos;
	logic signed [WORD_W-1:0] cell_data [DEPTH];
	logic                     full;
	logic                     empty;
	logic [CNT_W-1:0]         tail;

	// unpack the request word
	assign kind     = s_axis_tuser;
	assign value    = s_axis_tdata[WORD_W-1:0];
	assign position = s_axis_tdata[WORD_W+CNT_W-1:WORD_W];

	// accept while the output register is free or being drained
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign tail  = count_q - 1'b1;

	// decode the request into a cell command, a status and the new count
	always_comb begin
		ctl.mode   = CELL_HOLD;
		ctl.word   = value;
		cell_pos   = '0;
		status_nxt = ST_OK;
		take       = 1'b0;
		rd_pos     = '0;
		count_nxt  = count_q;
		unique case (kind)
			K_PUSH_FRONT, K_PUSH_BACK: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					ctl.mode  = CELL_OPEN;
					cell_pos  = (kind == K_PUSH_FRONT) ? '0 : count_q;
					count_nxt = count_q + 1'b1;
				end
			end
			K_POP_FRONT, K_POP_BACK: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					ctl.mode  = CELL_CLOSE;
					cell_pos  = (kind == K_POP_FRONT) ? '0 : tail;
					rd_pos    = cell_pos;
					take      = 1'b1;
					count_nxt = tail;
				end
			end
			K_INSERT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else if (position > count_q) begin
					status_nxt = ST_RANGE;
				end else begin
					ctl.mode  = CELL_OPEN;
					cell_pos  = position;
					count_nxt = count_q + 1'b1;
				end
			end
			K_ERASE: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else if (position >= count_q) begin
					status_nxt = ST_RANGE;
				end else begin
					ctl.mode  = CELL_CLOSE;
					cell_pos  = position;
					count_nxt = tail;
				end
			end
			default: begin
			end
		endcase
		// cells move only on an accepted request
		if (!in_acc) begin
			ctl.mode = CELL_HOLD;
		end
	end

	// row of cells, each linked to both neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [WORD_W-1:0] left_w;
		logic signed [WORD_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end
		ids_cell #(
			.CNT_W (CNT_W),
			.INDEX (i)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.pos   (cell_pos),
			.left  (left_w),
			.right (right_w),
			.data  (cell_data[i])
		);
	end

	// count and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// capture the result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			taken_q  <= take ? cell_data[rd_pos[IDX_W-1:0]] : '0;
			status_q <= status_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({count_q, status_q, taken_q});

	// the count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above depth");

	// a pop on a non-empty store succeeds and drops the count by one
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (kind == K_POP_FRONT || kind == K_POP_BACK) && !empty)
		|=> (status_q == ST_OK && count_q == $past(count_q) - 1'b1))
		else $error("pop did not remove one entry");

	// a push on a full store is flagged and leaves the count alone
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (kind == K_PUSH_FRONT || kind == K_PUSH_BACK) && full)
		|=> (status_q == ST_FULL && $stable(count_q)))
		else $error("push on full store not dropped");

	// a failed request never carries a popped word
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && status_nxt != ST_OK) |=> (taken_q == '0))
		else $error("failed request returned a word");

endmodule

// File: hdl/ids_cell.sv
module ids_cell
	import ids_pkg::*;
#(
	parameter int CNT_W = 7,
	parameter int INDEX = 0
) (
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic [CNT_W-1:0]         pos,
	input  logic signed [WORD_W-1:0] left,
	input  logic signed [WORD_W-1:0] right,
	output logic signed [WORD_W-1:0] data
);

	localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);

	logic signed [WORD_W-1:0] data_q;

	// open a gap: cells behind pos take from the left, pos loads the word;
	// close a gap: cells from pos on take from the right
	always_ff @(posedge clk) begin
		unique case (ctl.mode)
			CELL_OPEN: begin
				if (MY_POS > pos) begin
					data_q <= left;
				end else if (MY_POS == pos) begin
					data_q <= ctl.word;
				end
			end
			CELL_CLOSE: begin
				if (MY_POS >= pos) begin
					data_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;

endmodule
